### rtl/wblm_pkg.sv
// shared types and helpers for the word box line merger
// box and event structs, saturating edge sum; no dependencies
package wblm_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int BOX_W       = 4 * COORD_WIDTH;
  localparam int QUEUE_DEPTH = 2;

  typedef logic [COORD_WIDTH-1:0] coord_t;

  // x in the lowest bits
  typedef struct packed {
    coord_t h;
    coord_t w;
    coord_t y;
    coord_t x;
  } box_t;

  // results caused by one word
  typedef struct packed {
    logic close_vld;
    box_t close_box;
    logic last_vld;
    box_t last_box;
  } event_t;

  function automatic coord_t sat_add(coord_t a, coord_t b);
    logic [COORD_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COORD_WIDTH] ? {COORD_WIDTH{1'b1}} : s[COORD_WIDTH-1:0];
  endfunction

endpackage

### rtl/wblm_front.sv
// front end: accepts words, decides join or break, keeps line state
// produces one event per word that causes results; uses wblm_pkg
module wblm_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          word_vld,
  input  wblm_pkg::box_t word_box,
  input  logic          word_last,
  input  logic          q_full,
  output logic          word_rdy,
  output logic          ev_push,
  output wblm_pkg::event_t ev
);
  import wblm_pkg::*;

  box_t   prev_r, prev_nxt;
  box_t   line_r, line_nxt;
  logic   open_r, open_nxt;

  box_t   uni;
  coord_t prev_bot, cur_bot, prev_rt, thresh;
  coord_t a_rt, b_rt, a_bot, b_bot, rx, ry, rr, rb;
  logic [COORD_WIDTH:0] gap;
  logic   overlap, join_ok, accept;

  assign word_rdy = !q_full;
  assign accept   = word_vld && word_rdy;

  always_comb begin
    prev_bot = sat_add(prev_r.y, prev_r.h);
    cur_bot  = sat_add(word_box.y, word_box.h);
    prev_rt  = sat_add(prev_r.x, prev_r.w);
    overlap  = (word_box.y <= prev_r.y && cur_bot > prev_r.y) ||
               (prev_r.y <= word_box.y && prev_bot > word_box.y);
    gap      = {1'b0, word_box.x} - {1'b0, prev_rt};
    thresh   = (word_box.h < prev_r.h) ? word_box.h : prev_r.h;
    join_ok  = open_r && overlap && (word_box.x > prev_rt) &&
               (gap[COORD_WIDTH-1:0] < thresh);

    // rectangle union of open line and word
    a_rt  = sat_add(line_r.x, line_r.w);
    b_rt  = sat_add(word_box.x, word_box.w);
    a_bot = sat_add(line_r.y, line_r.h);
    b_bot = cur_bot;
    rx    = (line_r.x < word_box.x) ? line_r.x : word_box.x;
    ry    = (line_r.y < word_box.y) ? line_r.y : word_box.y;
    rr    = (a_rt > b_rt) ? a_rt : b_rt;
    rb    = (a_bot > b_bot) ? a_bot : b_bot;
    if (line_r.w == '0 || line_r.h == '0) begin
      uni = word_box;
    end else if (word_box.w == '0 || word_box.h == '0) begin
      uni = line_r;
    end else begin
      uni.x = rx;
      uni.y = ry;
      uni.w = rr - rx;
      uni.h = rb - ry;
    end

    prev_nxt = prev_r;
    line_nxt = line_r;
    open_nxt = open_r;
    ev.close_vld = 1'b0;
    ev.close_box = line_r;
    ev.last_vld  = 1'b0;
    if (accept) begin
      prev_nxt = word_box;
      if (join_ok) begin
        line_nxt = uni;
      end else begin
        ev.close_vld = open_r;
        line_nxt     = word_box;
        open_nxt     = 1'b1;
      end
      if (word_last) begin
        ev.last_vld = 1'b1;
        open_nxt    = 1'b0;
      end
    end
    ev.last_box = line_nxt;
    ev_push     = ev.close_vld || ev.last_vld;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      line_r <= '0;
      open_r <= 1'b0;
    end else begin
      prev_r <= prev_nxt;
      line_r <= line_nxt;
      open_r <= open_nxt;
    end
  end

endmodule

### rtl/wblm_queue.sv
// short event queue between front and back ends
// register array with read and write pointers; uses wblm_pkg
module wblm_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  wblm_pkg::event_t push_ev,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output wblm_pkg::event_t head
);
  import wblm_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  event_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_r, rd_r;
  logic [PTR_W:0]     cnt_r;

  assign full  = (cnt_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

### rtl/wblm_back.sv
// back end: expands events into line results through an output register
// closed line first, then the last line; uses wblm_pkg
module wblm_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  wblm_pkg::event_t head,
  output logic          pop,
  output logic          out_vld,
  output wblm_pkg::box_t out_box,
  output logic          out_last,
  input  logic          out_rdy
);
  import wblm_pkg::*;

  logic vld_r, vld_nxt;
  box_t box_r, box_nxt;
  logic last_r, last_nxt;
  logic sub_r, sub_nxt;
  logic load;

  assign out_vld  = vld_r;
  assign out_box  = box_r;
  assign out_last = last_r;

  always_comb begin
    load     = !q_empty && (!vld_r || out_rdy);
    vld_nxt  = vld_r && !out_rdy;
    box_nxt  = box_r;
    last_nxt = last_r;
    sub_nxt  = sub_r;
    pop      = 1'b0;
    if (load) begin
      vld_nxt = 1'b1;
      if (head.close_vld && !sub_r) begin
        box_nxt  = head.close_box;
        last_nxt = 1'b0;
        if (head.last_vld) begin
          sub_nxt = 1'b1;
        end else begin
          pop = 1'b1;
        end
      end else begin
        box_nxt  = head.last_box;
        last_nxt = 1'b1;
        sub_nxt  = 1'b0;
        pop      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      sub_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      sub_r <= sub_nxt;
    end
    box_r  <= box_nxt;
    last_r <= last_nxt;
  end

endmodule

### rtl/word_box_line_merger_top.sv
// top level of the word box line merger
// instantiates wblm_front, wblm_queue and wblm_back; uses wblm_pkg
//
// words enter on the in_ stream in reading order, line boxes leave on the out_ stream.
// a word is either merged into the open line or closes it and starts a new one;
// in_tlast closes the page and emits the open line with out_tlast set.
// the front end decides each word in the cycle it is accepted, so one word per
// cycle is taken as long as the two-entry event queue has room.
// a line passes from the word that causes it through the event queue into the output
// register. a word that both breaks a line and is last yields two transactions
// on out_, one per cycle while out_tready holds high, via the single output register.
// when the receiver stalls, out_ holds its transaction, the queue fills and then
// in_tready drops. reset clears line state, the queue and the output valid.
module word_box_line_merger_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [wblm_pkg::BOX_W-1:0]    in_tdata,  // word_x, word_y, word_w, word_h
  input  logic                          in_tlast,  // word_last
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [wblm_pkg::BOX_W-1:0]    out_tdata, // line_x, line_y, line_w, line_h
  output logic                          out_tlast  // line_last
);
  import wblm_pkg::*;

  logic   q_full, q_empty, ev_push, pop;
  event_t ev, head;
  box_t   out_box;

  wblm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .word_vld  (in_tvalid),
    .word_box  (box_t'(in_tdata)),
    .word_last (in_tlast),
    .q_full    (q_full),
    .word_rdy  (in_tready),
    .ev_push   (ev_push),
    .ev        (ev)
  );

  wblm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (ev_push),
    .push_ev (ev),
    .pop     (pop),
    .full    (q_full),
    .empty   (q_empty),
    .head    (head)
  );

  wblm_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .head     (head),
    .pop      (pop),
    .out_vld  (out_tvalid),
    .out_box  (out_box),
    .out_last (out_tlast),
    .out_rdy  (out_tready)
  );

  assign out_tdata = out_box;

endmodule
